// ===== rtl/decimal_text_to_q8_8_converter_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the decimal text to Q7.8 converter
// Concurrent checks, compiled in simulation only.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_TEXT_TO_Q8_8_CONVERTER_CORE_ASSERT_SVH
`define DECIMAL_TEXT_TO_Q8_8_CONVERTER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define DTQ_ASSERT_SAME(LABEL, CLK, RSTN, ANTE, CONS) \
    LABEL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |-> (CONS)) \
        else $error("dtq check failed");
// The consequent must hold in the cycle after the antecedent.
`define DTQ_ASSERT_NEXT(LABEL, CLK, RSTN, ANTE, CONS) \
    LABEL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |=> (CONS)) \
        else $error("dtq check failed");
`else
`define DTQ_ASSERT_SAME(LABEL, CLK, RSTN, ANTE, CONS)
`define DTQ_ASSERT_NEXT(LABEL, CLK, RSTN, ANTE, CONS)
`endif
`endif

// ===== rtl/dtq_pkg.sv =====
// ----------------------------------------------------------------------------
// dtq_pkg
// Shared types, codes and defaults of the decimal text converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dtq_pkg;

    localparam int FRAC_BITS_DEF       = 8;
    localparam int INT_BITS_DEF        = 7;
    localparam int MAX_FRAC_DIGITS_DEF = 5;
    localparam int MAX_CHARS_DEF       = 15;
    localparam int QUEUE_DEPTH         = 2;

    localparam logic [7:0] CHAR_PLUS  = 8'd43;
    localparam logic [7:0] CHAR_MINUS = 8'd45;
    localparam logic [7:0] CHAR_POINT = 8'd46;
    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_NINE  = 8'd57;

    typedef enum logic [1:0] {
        PH_START,
        PH_INT,
        PH_FRAC
    } dtq_phase_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BADCHAR = 2'd1,
        ST_RANGE   = 2'd2
    } dtq_status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_DONE
    } dtq_back_state_t;

    // Per-job flags carried from the front to the back.
    typedef struct packed {
        logic        sign;
        dtq_status_t status;
    } dtq_flags_t;

endpackage

// ===== rtl/dtq_char_if.sv =====
// ----------------------------------------------------------------------------
// dtq_char_if
// Character channel: one ASCII character or an end marker per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dtq_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_text;

    modport source (output valid, output char_code, output end_of_text, input ready);
    modport sink (input valid, input char_code, input end_of_text, output ready);
endinterface

// ===== rtl/dtq_result_if.sv =====
// ----------------------------------------------------------------------------
// dtq_result_if
// Result channel: one sign-magnitude fixed-point word and a status per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dtq_result_if #(
    parameter int WORD_W = 16
);
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] fixed_value;
    logic [1:0]        status;

    modport source (output valid, output fixed_value, output status, input ready);
    modport sink (input valid, input fixed_value, input status, output ready);
endinterface

// ===== rtl/dtq_queue.sv =====
// ----------------------------------------------------------------------------
// dtq_queue
// Small register FIFO that decouples the parser from the scaling unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dtq_queue #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] din,
    input  logic         pop,
    output logic [W-1:0] dout,
    output logic         full,
    output logic         empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    logic [W-1:0]     mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end
endmodule

// ===== rtl/dtq_front.sv =====
// ----------------------------------------------------------------------------
// dtq_front
// Character parser: classifies each character and builds one job per text.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "decimal_text_to_q8_8_converter_core_assert.svh"

module dtq_front #(
    parameter int INT_BITS        = 7,
    parameter int MAX_FRAC_DIGITS = 5,
    parameter int MAX_CHARS       = 15,
    parameter int POW_W           = 17
) (
    input  logic                clk,
    input  logic                rst_n,
    dtq_char_if.sink            chars,
    input  logic                full,
    output logic                push,
    output dtq_pkg::dtq_flags_t job_flags,
    output logic [INT_BITS-1:0] job_int,
    output logic [POW_W-1:0]    job_acc,
    output logic [POW_W-1:0]    job_pow
);
    import dtq_pkg::*;

    localparam int FC_W = $clog2(MAX_FRAC_DIGITS + 1);
    localparam int CC_W = $clog2(MAX_CHARS + 1);
    localparam int IW   = INT_BITS + 5;
    localparam logic [INT_BITS:0] INT_LIMIT = {1'b1, {INT_BITS{1'b0}}};

    dtq_phase_t        phase_reg, phase_next;
    logic              sign_reg, sign_next;
    logic [INT_BITS:0] int_reg, int_next;
    logic [POW_W-1:0]  acc_reg, acc_next;
    logic [POW_W-1:0]  pow_reg, pow_next;
    logic [FC_W-1:0]   fcnt_reg, fcnt_next;
    dtq_status_t       err_reg, err_next;
    logic [CC_W-1:0]   cc_reg, cc_next;

    logic              accept;
    logic              is_end;
    logic              take;
    logic              ignore;
    logic              is_digit;
    logic [3:0]        digit;
    logic [IW-1:0]     int_wide;
    logic [INT_BITS:0] int_digit;

    assign chars.ready = !full;
    assign accept      = chars.valid && chars.ready;
    assign is_end      = accept && chars.end_of_text;
    assign take        = accept && !chars.end_of_text;
    assign is_digit    = chars.char_code inside {[CHAR_ZERO:CHAR_NINE]};
    assign digit       = chars.char_code[3:0];

    // Integer accumulator times ten plus the digit, saturating just above range.
    assign int_wide  = (IW'(int_reg) << 3) + (IW'(int_reg) << 1) + IW'(digit);
    assign int_digit = (int_wide > IW'(INT_LIMIT)) ? INT_LIMIT : int_wide[INT_BITS:0];

    assign ignore = (err_reg != ST_OK) || (cc_reg >= CC_W'(MAX_CHARS))
                 || ((phase_reg == PH_FRAC) && (fcnt_reg >= FC_W'(MAX_FRAC_DIGITS)));

    always_comb
    begin
        job_flags.sign = sign_reg;
        if (err_reg != ST_OK)
        begin
            job_flags.status = err_reg;
        end
        else if (phase_reg == PH_START)
        begin
            job_flags.status = ST_BADCHAR;
        end
        else if ((phase_reg == PH_INT) && int_reg[INT_BITS])
        begin
            job_flags.status = ST_RANGE;
        end
        else
        begin
            job_flags.status = ST_OK;
        end
        job_int = int_reg[INT_BITS-1:0];
        job_acc = acc_reg;
        job_pow = pow_reg;
    end

    always_comb
    begin
        phase_next = phase_reg;
        sign_next  = sign_reg;
        int_next   = int_reg;
        acc_next   = acc_reg;
        pow_next   = pow_reg;
        fcnt_next  = fcnt_reg;
        err_next   = err_reg;
        cc_next    = cc_reg;
        push       = 1'b0;
        if (is_end)
        begin
            push       = 1'b1;
            phase_next = PH_START;
            sign_next  = 1'b0;
            int_next   = '0;
            acc_next   = '0;
            pow_next   = POW_W'(1);
            fcnt_next  = '0;
            err_next   = ST_OK;
            cc_next    = '0;
        end
        else if (take && !ignore)
        begin
            cc_next = cc_reg + 1'b1;
            case (phase_reg)
                PH_START:
                begin
                    if (chars.char_code == CHAR_PLUS)
                    begin
                        phase_next = PH_INT;
                    end
                    else if (chars.char_code == CHAR_MINUS)
                    begin
                        sign_next  = 1'b1;
                        phase_next = PH_INT;
                    end
                    else if (is_digit)
                    begin
                        int_next   = int_digit;
                        phase_next = PH_INT;
                    end
                    else
                    begin
                        err_next = ST_BADCHAR;
                    end
                end
                PH_INT:
                begin
                    if (is_digit)
                    begin
                        int_next = int_digit;
                    end
                    else if (chars.char_code == CHAR_POINT)
                    begin
                        if (int_reg[INT_BITS])
                        begin
                            err_next = ST_RANGE;
                        end
                        phase_next = PH_FRAC;
                    end
                    else
                    begin
                        err_next = ST_BADCHAR;
                    end
                end
                PH_FRAC:
                begin
                    if (is_digit)
                    begin
                        acc_next  = (acc_reg << 3) + (acc_reg << 1) + POW_W'(digit);
                        pow_next  = (pow_reg << 3) + (pow_reg << 1);
                        fcnt_next = fcnt_reg + 1'b1;
                    end
                    else
                    begin
                        err_next = ST_BADCHAR;
                    end
                end
                default:
                begin
                    phase_next = PH_START;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            sign_reg  <= 1'b0;
            int_reg   <= '0;
            acc_reg   <= '0;
            pow_reg   <= POW_W'(1);
            fcnt_reg  <= '0;
            err_reg   <= ST_OK;
            cc_reg    <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            sign_reg  <= sign_next;
            int_reg   <= int_next;
            acc_reg   <= acc_next;
            pow_reg   <= pow_next;
            fcnt_reg  <= fcnt_next;
            err_reg   <= err_next;
            cc_reg    <= cc_next;
        end
    end

    `DTQ_ASSERT_SAME(a_char_count_bound, clk, rst_n, 1'b1, cc_reg <= CC_W'(MAX_CHARS))
    `DTQ_ASSERT_SAME(a_frac_acc_below_pow, clk, rst_n, 1'b1, acc_reg < pow_reg)
    `DTQ_ASSERT_NEXT(a_error_sticky, clk, rst_n, (err_reg != ST_OK) && !is_end, err_reg == $past(err_reg))
endmodule

// ===== rtl/dtq_back.sv =====
// ----------------------------------------------------------------------------
// dtq_back
// Scaling unit: divides the fraction digits into binary, one bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "decimal_text_to_q8_8_converter_core_assert.svh"

module dtq_back #(
    parameter int INT_BITS  = 7,
    parameter int FRAC_BITS = 8,
    parameter int POW_W     = 17
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_valid,
    output logic                pop,
    input  dtq_pkg::dtq_flags_t job_flags,
    input  logic [INT_BITS-1:0] job_int,
    input  logic [POW_W-1:0]    job_acc,
    input  logic [POW_W-1:0]    job_pow,
    dtq_result_if.source        result
);
    import dtq_pkg::*;

    localparam int WORD_W = 1 + INT_BITS + FRAC_BITS;
    localparam int BC_W   = $clog2(FRAC_BITS + 1);

    dtq_back_state_t      state_reg, state_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_load;

    logic [POW_W:0]       rem_reg, rem_next;
    logic [POW_W-1:0]     pow_reg, pow_next;
    logic [FRAC_BITS-1:0] quo_reg, quo_next;
    logic [BC_W-1:0]      bit_reg, bit_next;
    dtq_flags_t           flags_reg, flags_next;
    logic [INT_BITS-1:0]  int_reg, int_next;
    logic [WORD_W-1:0]    word_reg;
    logic [1:0]           status_reg;

    logic [POW_W:0]       trial;
    logic                 ge;

    assign trial = {rem_reg[POW_W-1:0], 1'b0};
    assign ge    = (trial >= {1'b0, pow_reg});

    always_comb
    begin
        state_next = state_reg;
        rem_next   = rem_reg;
        pow_next   = pow_reg;
        quo_next   = quo_reg;
        bit_next   = bit_reg;
        flags_next = flags_reg;
        int_next   = int_reg;
        pop        = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (job_valid)
                begin
                    pop        = 1'b1;
                    rem_next   = {1'b0, job_acc};
                    pow_next   = job_pow;
                    quo_next   = '0;
                    bit_next   = '0;
                    flags_next = job_flags;
                    int_next   = job_int;
                    state_next = BK_DIV;
                end
            end
            BK_DIV:
            begin
                rem_next = ge ? (trial - {1'b0, pow_reg}) : trial;
                quo_next = (quo_reg << 1) | FRAC_BITS'(ge);
                bit_next = bit_reg + 1'b1;
                if (bit_reg == BC_W'(FRAC_BITS - 1))
                begin
                    state_next = BK_DONE;
                end
            end
            BK_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_load   = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        pow_reg   <= pow_next;
        quo_reg   <= quo_next;
        bit_reg   <= bit_next;
        flags_reg <= flags_next;
        int_reg   <= int_next;
        if (out_load)
        begin
            status_reg <= flags_reg.status;
            if (flags_reg.status == ST_OK)
            begin
                word_reg <= {flags_reg.sign, int_reg, quo_reg};
            end
            else
            begin
                word_reg <= '0;
            end
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.fixed_value = word_reg;
    assign result.status      = status_reg;

    `DTQ_ASSERT_SAME(a_rem_below_divisor, clk, rst_n, state_reg == BK_DIV, rem_reg < {1'b0, pow_reg})
    `DTQ_ASSERT_NEXT(a_pop_starts_divide, clk, rst_n, pop, state_reg == BK_DIV)
    `DTQ_ASSERT_SAME(a_error_word_zero, clk, rst_n, out_valid_reg && (status_reg != ST_OK), word_reg == '0)
endmodule

// ===== rtl/decimal_text_to_q8_8_converter_core.sv =====
// ----------------------------------------------------------------------------
// decimal_text_to_q8_8_converter_core: decimal text to sign-magnitude Q7.8
// Throughput: one beat per cycle while the two-entry job queue has room; the
// back end holds one text at a time, through the bit-serial scaling divider,
// and pops the next job only after the result of the last one is loaded.
// Reset (rst_n, asynchronous) clears the parser, the queue and the result stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// The front end parses one character per beat. It tracks the sign, a
// saturating integer accumulator, the fraction digits as an integer together
// with the matching power of ten, and the first error seen. On the end marker
// it pushes a job with those values and its final status into a short queue,
// and clears itself for the next text in the same cycle.
//
// The back end pops a job and turns the decimal fraction into binary by a
// restoring division of fraction * 2^FRAC_BITS by the power of ten, one
// quotient bit per cycle. The fraction is always below the power of ten, so
// the quotient fits in FRAC_BITS bits and the remainder never grows beyond
// one bit over the divisor. A job with a bad status still runs through the
// divider, but its result word is forced to zero.
//
// The result sits in an output register, so the back end can finish the next
// job while a result waits to be taken, and the front end keeps parsing while
// the back end is busy.
module decimal_text_to_q8_8_converter_core #(
    parameter int FRAC_BITS       = dtq_pkg::FRAC_BITS_DEF,
    parameter int INT_BITS        = dtq_pkg::INT_BITS_DEF,
    parameter int MAX_FRAC_DIGITS = dtq_pkg::MAX_FRAC_DIGITS_DEF,
    parameter int MAX_CHARS       = dtq_pkg::MAX_CHARS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    dtq_char_if.sink     chars,
    dtq_result_if.source result
);
    import dtq_pkg::*;

    // Width of the fraction accumulator and of the power of ten: both stay
    // at or below 10^MAX_FRAC_DIGITS.
    localparam int POW_W   = $clog2((10 ** MAX_FRAC_DIGITS) + 1);
    localparam int FLAGS_W = $bits(dtq_flags_t);
    localparam int JOB_W   = FLAGS_W + INT_BITS + 2 * POW_W;

    logic                push;
    logic                pop;
    logic                q_full;
    logic                q_empty;
    logic [JOB_W-1:0]    q_din;
    logic [JOB_W-1:0]    q_dout;

    dtq_flags_t          f_flags;
    logic [INT_BITS-1:0] f_int;
    logic [POW_W-1:0]    f_acc;
    logic [POW_W-1:0]    f_pow;

    dtq_flags_t          b_flags;
    logic [INT_BITS-1:0] b_int;
    logic [POW_W-1:0]    b_acc;
    logic [POW_W-1:0]    b_pow;

    dtq_front #(
        .INT_BITS        (INT_BITS),
        .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS),
        .MAX_CHARS       (MAX_CHARS),
        .POW_W           (POW_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .chars     (chars),
        .full      (q_full),
        .push      (push),
        .job_flags (f_flags),
        .job_int   (f_int),
        .job_acc   (f_acc),
        .job_pow   (f_pow)
    );

    assign q_din = {f_flags, f_int, f_acc, f_pow};

    dtq_queue #(
        .W     (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (q_din),
        .pop   (pop),
        .dout  (q_dout),
        .full  (q_full),
        .empty (q_empty)
    );

    // Unpack the job in the same field order as it was packed.
    assign b_flags = dtq_flags_t'(q_dout[JOB_W-1 -: FLAGS_W]);
    assign b_int   = q_dout[2*POW_W +: INT_BITS];
    assign b_acc   = q_dout[POW_W +: POW_W];
    assign b_pow   = q_dout[POW_W-1:0];

    dtq_back #(
        .INT_BITS  (INT_BITS),
        .FRAC_BITS (FRAC_BITS),
        .POW_W     (POW_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (!q_empty),
        .pop       (pop),
        .job_flags (b_flags),
        .job_int   (b_int),
        .job_acc   (b_acc),
        .job_pow   (b_pow),
        .result    (result)
    );
endmodule
